// ----- sv/ssmr_pkg.sv -----
// ----------------------------------------------------------------------------
// ssmr_pkg: shared types and constants of the slow-motion servo ramp
// Holds the operation and motion codes, register indexes, limits and the
// structs that pass between the ramp datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ssmr_pkg;

  // input operation codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_CLOSE = 2'd1,
    OP_THROW = 2'd2,
    OP_JUMP  = 2'd3
  } op_t;

  // motion codes, code 3 is never produced
  typedef enum logic [1:0] {
    MOT_IDLE = 2'd0,
    MOT_DOWN = 2'd1,
    MOT_UP   = 2'd2
  } motion_t;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_INTERVAL = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_STEP     = 2'd3;

  // limits and reset values
  localparam logic [7:0]         ANGLE_LIMIT   = 8'd180;
  localparam logic [16:0]        ELAPSED_MAX   = 17'h1FFFF;
  localparam logic signed [9:0]  GOAL_NONE     = 10'sd511;
  localparam logic [7:0]         MIN_RESET     = 8'd0;
  localparam logic [7:0]         MAX_RESET     = 8'd180;
  localparam logic [15:0]        INTERVAL_RESET = 16'd20;
  localparam logic [4:0]         BACK_RESET    = 5'd0;

  // configuration registers
  typedef struct packed {
    logic [7:0]  min_angle;
    logic [7:0]  max_angle;
    logic [15:0] step_interval;
    logic [4:0]  back_step;
  } ssmr_cfg_t;

  // ramp state carried from item to item
  typedef struct packed {
    motion_t            motion;
    logic signed [8:0]  angle;
    logic signed [9:0]  goal;
    logic [16:0]        elapsed;
    logic               end_flag;
  } ssmr_state_t;

  // per-item result flags
  typedef struct packed {
    logic written;
    logic finished;
  } ssmr_flags_t;

endpackage

`default_nettype wire

// ----- sv/ssmr_if.sv -----
// ----------------------------------------------------------------------------
// ssmr_if: valid/ready channels of the slow-motion servo ramp
// Input channel carries the operation and jump angle, output channel the
// servo position and status of one processed word.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssmr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] target_angle;

  modport source (output valid, output operation, output target_angle, input ready);
  modport sink   (input valid, input operation, input target_angle, output ready);
endinterface

interface ssmr_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] servo_angle;
  logic              angle_written;
  logic              finished;
  logic [1:0]        motion;
  logic              at_max_end;

  modport source (output valid, output servo_angle, output angle_written,
                  output finished, output motion, output at_max_end, input ready);
  modport sink   (input valid, input servo_angle, input angle_written,
                  input finished, input motion, input at_max_end, output ready);
endinterface

`default_nettype wire

// ----- sv/ssmr_step.sv -----
// ----------------------------------------------------------------------------
// ssmr_step: next-state logic of the servo ramp
// Applies one tick, command or jump to the ramp state and reports whether
// the position was written and whether a motion completed.
// ----------------------------------------------------------------------------
`default_nettype none

module ssmr_step (
  input  ssmr_pkg::ssmr_cfg_t   cfg,
  input  ssmr_pkg::ssmr_state_t cur,
  input  ssmr_pkg::op_t         op,
  input  logic [7:0]            target_angle,
  output ssmr_pkg::ssmr_state_t nxt,
  output ssmr_pkg::ssmr_flags_t flags
);
  import ssmr_pkg::*;

  logic [7:0]        min_cl;
  logic [7:0]        max_cl;
  logic signed [9:0] low_rest;
  logic signed [9:0] high_rest;
  logic signed [9:0] goal_lo;
  logic signed [9:0] goal_hi;
  logic [16:0]       elapsed_inc;
  logic              step_due;
  logic signed [9:0] angle_ext;
  logic signed [9:0] angle_dn;
  logic signed [9:0] angle_up;

  // end points clamped to the angle limit, rest and overshoot goals
  assign min_cl    = (cfg.min_angle > ANGLE_LIMIT) ? ANGLE_LIMIT : cfg.min_angle;
  assign max_cl    = (cfg.max_angle > ANGLE_LIMIT) ? ANGLE_LIMIT : cfg.max_angle;
  assign low_rest  = $signed({2'b00, min_cl}) - 10'sd1;
  assign high_rest = $signed({2'b00, max_cl}) + 10'sd1;
  assign goal_lo   = low_rest - $signed({5'b00000, cfg.back_step});
  assign goal_hi   = high_rest + $signed({5'b00000, cfg.back_step});

  // saturating tick count and step decision
  assign elapsed_inc = (cur.elapsed != ELAPSED_MAX) ? cur.elapsed + 17'd1 : cur.elapsed;
  assign step_due    = (cur.motion != MOT_IDLE) && (elapsed_inc > {1'b0, cfg.step_interval});

  // one degree either way, one bit wider so an up step from the top still compares
  assign angle_ext = {cur.angle[8], cur.angle};
  assign angle_dn  = angle_ext - 10'sd1;
  assign angle_up  = angle_ext + 10'sd1;

  // apply the operation
  always_comb begin
    nxt            = cur;
    flags.written  = 1'b0;
    flags.finished = 1'b0;
    unique case (op)
      OP_TICK: begin
        nxt.elapsed = elapsed_inc;
        if (step_due) begin
          nxt.elapsed   = '0;
          flags.written = 1'b1;
          if (cur.motion == MOT_DOWN) begin
            if (angle_dn <= cur.goal) begin
              nxt.motion     = MOT_IDLE;
              nxt.end_flag   = 1'b0;
              nxt.angle      = low_rest[8:0];
              flags.finished = 1'b1;
            end else begin
              nxt.angle = angle_dn[8:0];
            end
          end else begin
            if (angle_up >= cur.goal) begin
              nxt.motion     = MOT_IDLE;
              nxt.end_flag   = 1'b1;
              nxt.angle      = high_rest[8:0];
              flags.finished = 1'b1;
            end else begin
              nxt.angle = angle_up[8:0];
            end
          end
        end
      end
      OP_CLOSE: begin
        if (cur.goal != goal_hi) begin
          nxt.motion = MOT_UP;
          nxt.goal   = goal_hi;
        end
      end
      OP_THROW: begin
        if (cur.goal != goal_lo) begin
          nxt.motion = MOT_DOWN;
          nxt.goal   = goal_lo;
        end
      end
      OP_JUMP: begin
        nxt.angle     = $signed({1'b0, target_angle});
        flags.written = 1'b1;
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/servo_slow_motion_ramp.sv -----
// an accepted word passes through the input register and then the output register
// throughput: one word per cycle unless backpressure stalls; the ramp state is updated in the single step stage
// backpressure stalls the step stage and the input register while the result waits
// reset (rst_n low, synchronous): idle, position 0, no goal, tick count saturated
// reset also loads min 0, max 180, step interval 20 and back step 0
// ----------------------------------------------------------------------------
// servo_slow_motion_ramp: slow-motion servo ramp top level
// Input register, one step stage that updates the ramp state, and an output
// register; configuration registers are written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module servo_slow_motion_ramp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [ssmr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ssmr_pkg::CFG_DATA_W-1:0]       cfg_data,
  ssmr_in_if.sink                               in_ch,
  ssmr_out_if.source                            out_ch
);
  import ssmr_pkg::*;

  ssmr_cfg_t   cfg_r;
  ssmr_state_t state_r;
  ssmr_state_t state_nxt;
  ssmr_flags_t flags;

  logic        stage_valid_r;
  op_t         stage_op_r;
  logic [7:0]  stage_tgt_r;
  logic        out_valid_r;
  logic signed [8:0] out_angle_r;
  logic        out_written_r;
  logic        out_finished_r;
  motion_t     out_motion_r;
  logic        out_end_r;
  logic        advance;

  // stage moves on when the output register is free or being emptied
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !stage_valid_r || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_angle     <= MIN_RESET;
      cfg_r.max_angle     <= MAX_RESET;
      cfg_r.step_interval <= INTERVAL_RESET;
      cfg_r.back_step     <= BACK_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_ANGLE:     cfg_r.min_angle     <= cfg_data[7:0];
        CFG_MAX_ANGLE:     cfg_r.max_angle     <= cfg_data[7:0];
        CFG_STEP_INTERVAL: cfg_r.step_interval <= cfg_data;
        CFG_BACK_STEP:     cfg_r.back_step     <= cfg_data[4:0];
        default:           cfg_r               <= cfg_r;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stage_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage_op_r  <= op_t'(in_ch.operation);
      stage_tgt_r <= in_ch.target_angle;
    end
  end

  // ramp step
  ssmr_step u_step (
    .cfg          (cfg_r),
    .cur          (state_r),
    .op           (stage_op_r),
    .target_angle (stage_tgt_r),
    .nxt          (state_nxt),
    .flags        (flags)
  );

  // ramp state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.motion   <= MOT_IDLE;
      state_r.angle    <= '0;
      state_r.goal     <= GOAL_NONE;
      state_r.elapsed  <= ELAPSED_MAX;
      state_r.end_flag <= 1'b0;
    end else if (stage_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= stage_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_valid_r && advance) begin
      out_angle_r    <= state_nxt.angle;
      out_written_r  <= flags.written;
      out_finished_r <= flags.finished;
      out_motion_r   <= state_nxt.motion;
      out_end_r      <= state_nxt.end_flag;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.servo_angle   = out_angle_r;
  assign out_ch.angle_written = out_written_r;
  assign out_ch.finished      = out_finished_r;
  assign out_ch.motion        = out_motion_r;
  assign out_ch.at_max_end    = out_end_r;

`ifndef ASSERT_OFF
  // a completed motion always wrote the snap-back position and left motion idle
  a_finish_written: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_finished_r) |-> (out_written_r && out_motion_r == MOT_IDLE))
    else $error("finished without a written idle position");

  // a held result keeps its position while the step stage is stalled
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_angle_r) && $stable(state_r))
    else $error("state or result changed under backpressure");

  // an empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with output register empty");

  // a moving ramp always has a goal set
  a_goal_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.motion != MOT_IDLE) |-> (state_r.goal != GOAL_NONE))
    else $error("motion without a goal");
`endif

endmodule

`default_nettype wire
